// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eulrot_pkg.sv =====
// ---------------------------------------------------------------------------
// eulrot_pkg
// shared types, constants and arithmetic helpers of the euler rotation block
// ---------------------------------------------------------------------------
`default_nettype none

package eulrot_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int OUT_W          = 16;
    localparam int TURN_W         = 32;
    localparam int WORK_FRAC      = 30;
    localparam int CORDIC_STEPS   = 30;
    localparam int XY_W           = 34;
    localparam int Z_W            = 33;
    localparam int TRIG_W         = 32;
    localparam int SUM_W          = TRIG_W + 1;
    localparam int PIPE_STAGES    = CORDIC_STEPS + 6;

    localparam int RND_SHIFT      = WORK_FRAC - COEF_FRAC_BITS;
    localparam int RND_HALF_POS   = (RND_SHIFT > 0) ? RND_SHIFT - 1 : 0;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [XY_W-1:0]       xy_t;
    typedef logic signed [Z_W-1:0]        zang_t;
    typedef logic signed [TRIG_W-1:0]     trig_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [SUM_W:0]        wide_t;
    typedef logic signed [OUT_W-1:0]      coef_t;

    localparam xy_t CORDIC_INV_GAIN = XY_W'(64'sd652032874);

    localparam wide_t RND_BIAS = (RND_SHIFT > 0) ? ((SUM_W+1)'(1) << RND_HALF_POS) : '0;
    localparam wide_t COEF_LIM = (SUM_W+1)'(1) << COEF_FRAC_BITS;
    localparam wide_t COEF_NEG_LIM = -COEF_LIM;

    localparam logic signed [2*TRIG_W-1:0] MUL_BIAS = (2*TRIG_W)'(1) << (WORK_FRAC - 1);

    localparam logic [TURN_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        trig_t cpcy;
        trig_t cysp;
        trig_t crsy;
        trig_t crcy;
        trig_t srsy;
        trig_t cpsy;
        trig_t spsr;
        trig_t crsp;
        trig_t cysr;
        trig_t cpsr;
        trig_t cpcr;
        trig_t sp;
        trig_t sr;
        trig_t sy;
    } prod1_t;

    typedef struct packed {
        trig_t cpcy;
        trig_t cyspsr;
        trig_t crsy;
        trig_t crcysp;
        trig_t srsy;
        trig_t cpsy;
        trig_t crcy;
        trig_t spsrsy;
        trig_t crspsy;
        trig_t cysr;
        trig_t sp;
        trig_t cpsr;
        trig_t cpcr;
    } prod2_t;

    typedef struct packed {
        sum_t e11;
        sum_t e12;
        sum_t e13;
        sum_t e21;
        sum_t e22;
        sum_t e23;
        sum_t e31;
        sum_t e32;
        sum_t e33;
    } sums_t;

    typedef struct packed {
        coef_t e11;
        coef_t e12;
        coef_t e13;
        coef_t e21;
        coef_t e22;
        coef_t e23;
        coef_t e31;
        coef_t e32;
        coef_t e33;
    } coefs_t;

    // q1.30 product, rounded half up
    function automatic trig_t fix_mul(trig_t a, trig_t b);
        logic signed [2*TRIG_W-1:0] p;
        begin
            p = a * b;
            p = p + MUL_BIAS;
            return trig_t'(p >>> WORK_FRAC);
        end
    endfunction

    function automatic coef_t round_sat(sum_t v);
        wide_t w;
        wide_t r;
        begin
            w = wide_t'(v);
            r = (w + RND_BIAS) >>> RND_SHIFT;
            if (r > COEF_LIM)
            begin
                r = COEF_LIM;
            end
            else if (r < COEF_NEG_LIM)
            begin
                r = COEF_NEG_LIM;
            end
            return coef_t'(r);
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/eulrot_sincos.sv =====
// ---------------------------------------------------------------------------
// eulrot_sincos
// pipelined rotation-mode cordic, one iteration per stage, sine and cosine
// ---------------------------------------------------------------------------
`default_nettype none

module eulrot_sincos
    import eulrot_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   adv,
    input  wire angle_t angle,
    output trig_t       sin_val,
    output trig_t       cos_val
);

    logic [TURN_W-1:0]        turn;
    logic                     flip;
    logic signed [TURN_W-1:0] zturn;

    xy_t   x_reg [CORDIC_STEPS+1];
    xy_t   y_reg [CORDIC_STEPS+1];
    zang_t z_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] flip_reg;

    xy_t   x_next [CORDIC_STEPS];
    xy_t   y_next [CORDIC_STEPS];
    zang_t z_next [CORDIC_STEPS];

    trig_t sin_reg;
    trig_t cos_reg;

    assign turn  = {angle, {(TURN_W-ANGLE_BITS){1'b0}}};
    assign flip  = turn[TURN_W-1] ^ turn[TURN_W-2];
    // second and third quadrant: rotate by half a turn, negate at the end
    assign zturn = {turn[TURN_W-1] ^ flip, turn[TURN_W-2:0]};

    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][Z_W-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - zang_t'(ATAN_TBL[i]);
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + zang_t'(ATAN_TBL[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= CORDIC_INV_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= zang_t'(zturn);
            flip_reg[0] <= flip;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                z_reg[i+1]    <= z_next[i];
                flip_reg[i+1] <= flip_reg[i];
            end
            if (flip_reg[CORDIC_STEPS])
            begin
                sin_reg <= trig_t'(-y_reg[CORDIC_STEPS]);
                cos_reg <= trig_t'(-x_reg[CORDIC_STEPS]);
            end
            else
            begin
                sin_reg <= trig_t'(y_reg[CORDIC_STEPS]);
                cos_reg <= trig_t'(x_reg[CORDIC_STEPS]);
            end
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

// ===== src/euler_rotation_matrix.sv =====
// ---------------------------------------------------------------------------
// euler_rotation_matrix
// z-y-x euler rotation matrix from pitch, roll and yaw binary angles
// ---------------------------------------------------------------------------
// usage:
//   input channel: in_valid/in_ready with pitch_angle, roll_angle, yaw_angle,
//   binary angles where half the full range is pi.
//   output channel: out_valid/out_ready with the nine entries row1_col1 ..
//   row3_col3 in q1.14, saturated to +-1.
//   pipeline: an accepted beat passes one angle stage, 30 cordic stages,
//   one sign stage, two multiplier stages, one sum stage and one rounding
//   stage that is also the output register.
//   throughput: one beat per cycle when the receiver does not stall, set
//   by the one-iteration-per-stage cordic and the registered multipliers.
//   stall: while out_valid is high and out_ready low the whole pipeline
//   holds, in_ready is low, and nothing is lost or repeated.
//   reset: rst_n clears all stage valid bits; the pipeline comes up empty
//   and in_ready is high in the first cycle after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module euler_rotation_matrix
    import eulrot_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire angle_t pitch_angle,
    input  wire angle_t roll_angle,
    input  wire angle_t yaw_angle,
    output logic        out_valid,
    input  wire logic   out_ready,
    output coef_t       row1_col1,
    output coef_t       row1_col2,
    output coef_t       row1_col3,
    output coef_t       row2_col1,
    output coef_t       row2_col2,
    output coef_t       row2_col3,
    output coef_t       row3_col1,
    output coef_t       row3_col2,
    output coef_t       row3_col3
);

    logic adv;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;

    trig_t sp, cp, sr, cr, sy, cy;

    prod1_t p1_reg, p1_next;
    prod2_t p2_reg, p2_next;
    sums_t  s_reg,  s_next;
    coefs_t o_reg,  o_next;

    assign adv      = !vld_reg[PIPE_STAGES-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[PIPE_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    eulrot_sincos u_pitch
    (
        .clk     (clk),
        .adv     (adv),
        .angle   (pitch_angle),
        .sin_val (sp),
        .cos_val (cp)
    );

    eulrot_sincos u_roll
    (
        .clk     (clk),
        .adv     (adv),
        .angle   (roll_angle),
        .sin_val (sr),
        .cos_val (cr)
    );

    eulrot_sincos u_yaw
    (
        .clk     (clk),
        .adv     (adv),
        .angle   (yaw_angle),
        .sin_val (sy),
        .cos_val (cy)
    );

    always_comb
    begin
        p1_next.cpcy = fix_mul(cp, cy);
        p1_next.cysp = fix_mul(cy, sp);
        p1_next.crsy = fix_mul(cr, sy);
        p1_next.crcy = fix_mul(cr, cy);
        p1_next.srsy = fix_mul(sr, sy);
        p1_next.cpsy = fix_mul(cp, sy);
        p1_next.spsr = fix_mul(sp, sr);
        p1_next.crsp = fix_mul(cr, sp);
        p1_next.cysr = fix_mul(cy, sr);
        p1_next.cpsr = fix_mul(cp, sr);
        p1_next.cpcr = fix_mul(cp, cr);
        p1_next.sp   = sp;
        p1_next.sr   = sr;
        p1_next.sy   = sy;
    end

    always_comb
    begin
        p2_next.cpcy   = p1_reg.cpcy;
        p2_next.cyspsr = fix_mul(p1_reg.cysp, p1_reg.sr);
        p2_next.crsy   = p1_reg.crsy;
        p2_next.crcysp = fix_mul(p1_reg.crcy, p1_reg.sp);
        p2_next.srsy   = p1_reg.srsy;
        p2_next.cpsy   = p1_reg.cpsy;
        p2_next.crcy   = p1_reg.crcy;
        p2_next.spsrsy = fix_mul(p1_reg.spsr, p1_reg.sy);
        p2_next.crspsy = fix_mul(p1_reg.crsp, p1_reg.sy);
        p2_next.cysr   = p1_reg.cysr;
        p2_next.sp     = p1_reg.sp;
        p2_next.cpsr   = p1_reg.cpsr;
        p2_next.cpcr   = p1_reg.cpcr;
    end

    always_comb
    begin
        s_next.e11 = sum_t'(p2_reg.cpcy);
        s_next.e12 = sum_t'(p2_reg.cyspsr) - sum_t'(p2_reg.crsy);
        s_next.e13 = sum_t'(p2_reg.crcysp) + sum_t'(p2_reg.srsy);
        s_next.e21 = sum_t'(p2_reg.cpsy);
        s_next.e22 = sum_t'(p2_reg.crcy) + sum_t'(p2_reg.spsrsy);
        s_next.e23 = sum_t'(p2_reg.crspsy) - sum_t'(p2_reg.cysr);
        s_next.e31 = -sum_t'(p2_reg.sp);
        s_next.e32 = sum_t'(p2_reg.cpsr);
        s_next.e33 = sum_t'(p2_reg.cpcr);
    end

    always_comb
    begin
        o_next.e11 = round_sat(s_reg.e11);
        o_next.e12 = round_sat(s_reg.e12);
        o_next.e13 = round_sat(s_reg.e13);
        o_next.e21 = round_sat(s_reg.e21);
        o_next.e22 = round_sat(s_reg.e22);
        o_next.e23 = round_sat(s_reg.e23);
        o_next.e31 = round_sat(s_reg.e31);
        o_next.e32 = round_sat(s_reg.e32);
        o_next.e33 = round_sat(s_reg.e33);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            s_reg  <= s_next;
            o_reg  <= o_next;
        end
    end

    assign out_valid = vld_reg[PIPE_STAGES-1];
    assign row1_col1 = o_reg.e11;
    assign row1_col2 = o_reg.e12;
    assign row1_col3 = o_reg.e13;
    assign row2_col1 = o_reg.e21;
    assign row2_col2 = o_reg.e22;
    assign row2_col3 = o_reg.e23;
    assign row3_col1 = o_reg.e31;
    assign row3_col2 = o_reg.e32;
    assign row3_col3 = o_reg.e33;

    `ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0], "accepted beat not in first stage")
    `ASSERT_NEXT(a_hold_freezes, !in_ready, $stable(vld_reg), "pipeline moved while held")
    `ASSERT_NEXT(a_bubble_follows, out_valid && out_ready && !vld_reg[PIPE_STAGES-2], !out_valid, "output beat repeated")

endmodule

`default_nettype wire
